### rtl/core/exl_pkg.sv
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types, constants and the fixed name table of the expression lexer.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LOOKAHEAD_DEF     = 7;
    localparam int NAME_COUNT        = 43;
    localparam int NAME_MAX          = 7;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [5:0] IDX_RPAREN = 6'd1;
    localparam logic [5:0] IDX_PLUS   = 6'd2;
    localparam logic [5:0] IDX_MINUS  = 6'd3;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [1:0] ARITY_NONE   = 2'd0;
    localparam logic [1:0] ARITY_UNARY  = 2'd1;
    localparam logic [1:0] ARITY_BINARY = 2'd2;

    typedef enum logic [2:0] {
        KIND_VALUE = 3'd0,
        KIND_PAREN = 3'd1,
        KIND_OPER  = 3'd2,
        KIND_FUNC  = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } t_in;

    typedef struct packed {
        t_kind       token_kind;
        logic [5:0]  name_index;
        logic [1:0]  arity;
        logic [15:0] value_start;
        logic [15:0] value_length;
        logic        last_token;
    } t_out;

    typedef struct packed {
        logic       has_chr;
        logic       last;
        logic [7:0] chr;
    } t_item;

    localparam logic [55:0] NAME_TEXT [NAME_COUNT] = '{
        56'("("), 56'(")"), 56'("+"), 56'("-"), 56'("*"), 56'("/"), 56'("^"),
        56'("%"), 56'("&&"), 56'("||"), 56'("<<"), 56'(">>"), 56'h00_0000_0000_C2B0,
        56'("!"), 56'("~"), 56'("min"), 56'("max"), 56'("pow"), 56'("mod"),
        56'("rem"), 56'("round"), 56'("acos"), 56'("asin"), 56'("atan"),
        56'("abs"), 56'("ln"), 56'("log"), 56'("floor"), 56'("ceiling"),
        56'("=="), 56'("!="), 56'("/="), 56'("<="), 56'(">="), 56'("~="),
        56'("&"), 56'("|"), 56'("cos"), 56'("sin"), 56'("tan"), 56'("ceil"),
        56'("<"), 56'(">")
    };

    localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd3, 3'd5, 3'd7,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd3, 3'd3,
        3'd3, 3'd4, 3'd1, 3'd1
    };

    function automatic logic [7:0] name_char(input int i, input int k);
        logic [55:0] al;
        al = NAME_TEXT[i] << (8 * (NAME_MAX - int'(NAME_LEN[i])));
        return al[55 - 8 * k -: 8];
    endfunction

    function automatic t_kind name_kind(input logic [5:0] idx);
        t_kind k;
        if (idx <= IDX_RPAREN) begin
            k = KIND_PAREN;
        end else if ((idx >= 6'd15 && idx <= 6'd28) || (idx >= 6'd37 && idx <= 6'd40)) begin
            k = KIND_FUNC;
        end else begin
            k = KIND_OPER;
        end
        return k;
    endfunction

endpackage

### rtl/core/exl_front.sv
// ----------------------------------------------------------------------------
// exl_front
// Input side: folds upper case, drops white space and queues the bytes.
// ----------------------------------------------------------------------------
module exl_front (
    input  logic           i_valid,
    input  exl_pkg::t_in   i_item,
    output logic           o_stall,
    input  logic           i_q_full,
    output logic           o_q_push,
    output exl_pkg::t_item o_q_item
);
    import exl_pkg::*;

    logic       space;
    logic [7:0] folded;

    always_comb begin
        space = (i_item.char_byte == CH_SPACE)
             || (i_item.char_byte >= CH_TAB && i_item.char_byte <= CH_CR);
        if (i_item.char_byte >= CH_UA && i_item.char_byte <= CH_UZ) begin
            folded = i_item.char_byte + CASE_GAP;
        end else begin
            folded = i_item.char_byte;
        end
        o_stall          = i_q_full;
        o_q_push         = i_valid && !i_q_full && (!space || i_item.last_char);
        o_q_item.has_chr = !space;
        o_q_item.last    = i_item.last_char;
        o_q_item.chr     = folded;
    end

endmodule

### rtl/core/exl_queue.sv
// ----------------------------------------------------------------------------
// exl_queue
// Short queue that decouples the input side from the token engine.
// ----------------------------------------------------------------------------
module exl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  exl_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output exl_pkg::t_item o_head
);
    import exl_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

endmodule

### rtl/core/exl_back.sv
// ----------------------------------------------------------------------------
// exl_back
// Token engine: value runs, lookahead buffer with longest name match,
// replay of unmatched bytes, end-of-expression flush and the result register.
// ----------------------------------------------------------------------------
module exl_back #(
    parameter int POSITION_BITS   = exl_pkg::POSITION_BITS_DEF,
    parameter int LOOKAHEAD_DEPTH = exl_pkg::LOOKAHEAD_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  exl_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output exl_pkg::t_out  o_token
);
    import exl_pkg::*;

    localparam int DEPTH = LOOKAHEAD_DEPTH;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);

    logic [7:0]               r_chr [DEPTH];
    logic [7:0]               n_chr [DEPTH];
    logic [15:0]              r_cpos [DEPTH];
    logic [15:0]              n_cpos [DEPTH];
    logic [CW-1:0]            r_n, n_n, r_m, n_m;
    logic                     r_run, n_run;
    logic [15:0]              r_run_start, n_run_start;
    logic [15:0]              r_run_len, n_run_len;
    logic                     r_pe, n_pe, r_pv, n_pv;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_flush, n_flush;
    logic                     r_hold_v, n_hold_v, r_out_v, n_out_v;
    t_out                     r_hold, n_hold, r_out, n_out;

    logic [7:0]    v_chr [DEPTH];
    logic [15:0]   v_pos [DEPTH];
    logic [7:0]    sh_chr [DEPTH];
    logic [15:0]   sh_pos [DEPTH];
    logic [CW-1:0] sh_amt, eval_cnt, m_eff, used;
    logic          pend, src_q, bare_q, hold_mode, can_emit;
    logic [7:0]    b;
    logic [15:0]   b_pos;
    logic          vb, is_e, waiting, do_emit;
    logic [NAME_MAX-1:0] len_hit;
    logic [5:0]    len_idx [NAME_MAX];
    logic [2:0]    best_len;
    logic [5:0]    best_idx;
    t_out          tok, run_tok, res_tok;

    always_comb begin
        pend   = (r_m != r_n);
        src_q  = !pend && !r_flush && i_q_valid && i_q_item.has_chr;
        bare_q = !pend && !r_flush && i_q_valid && !i_q_item.has_chr;
        v_chr  = r_chr;
        v_pos  = r_cpos;
        if (src_q) begin
            v_chr[r_n[IW-1:0]] = i_q_item.chr;
            v_pos[r_n[IW-1:0]] = 16'(r_pos);
        end
        m_eff    = src_q ? (r_n + CW'(1)) : r_m;
        eval_cnt = (pend || src_q) ? (r_n + CW'(1)) : r_n;
        b        = v_chr[r_n[IW-1:0]];
        b_pos    = v_pos[r_n[IW-1:0]];
        is_e     = (b == CH_E);
        vb       = (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || is_e
                || ((b == CH_PLUS || b == CH_MINUS) && r_pe);
    end

    // Name matching: one candidate per length, longest length wins.
    always_comb begin
        logic full;
        logic pre;
        len_hit = '0;
        waiting = 1'b0;
        for (int l = 0; l < NAME_MAX; l++) begin
            len_idx[l] = '0;
        end
        for (int i = 0; i < NAME_COUNT; i++) begin
            full = 1'b1;
            pre  = 1'b1;
            for (int k = 0; k < NAME_MAX; k++) begin
                if (k < int'(NAME_LEN[i]) && v_chr[k] != name_char(i, k)) begin
                    full = 1'b0;
                end
                if (k < int'(eval_cnt) && k < int'(NAME_LEN[i])
                        && v_chr[k] != name_char(i, k)) begin
                    pre = 1'b0;
                end
            end
            if (full && int'(NAME_LEN[i]) <= int'(eval_cnt)) begin
                len_hit[NAME_LEN[i] - 3'd1] = 1'b1;
                len_idx[NAME_LEN[i] - 3'd1] = len_idx[NAME_LEN[i] - 3'd1] | 6'(i);
            end
            if (pre && int'(NAME_LEN[i]) > int'(eval_cnt)) begin
                waiting = 1'b1;
            end
        end
        best_len = '0;
        best_idx = '0;
        for (int l = 0; l < NAME_MAX; l++) begin
            if (len_hit[l]) begin
                best_len = 3'(l + 1);
                best_idx = len_idx[l];
            end
        end
    end

    always_comb begin
        logic [CW:0] s;
        for (int j = 0; j < DEPTH; j++) begin
            s = (CW+1)'(j) + (CW+1)'(sh_amt);
            if (s < (CW+1)'(DEPTH)) begin
                sh_chr[j] = v_chr[s[IW-1:0]];
                sh_pos[j] = v_pos[s[IW-1:0]];
            end else begin
                sh_chr[j] = v_chr[j];
                sh_pos[j] = v_pos[j];
            end
        end
    end

    always_comb begin
        run_tok              = '0;
        run_tok.token_kind   = KIND_VALUE;
        run_tok.value_start  = r_run_start;
        run_tok.value_length = r_run_len;
        res_tok              = '0;
        if (best_len != '0) begin
            res_tok.token_kind = name_kind(best_idx);
            res_tok.name_index = best_idx;
            if (best_idx == IDX_PLUS || best_idx == IDX_MINUS) begin
                res_tok.arity = r_pv ? ARITY_BINARY : ARITY_UNARY;
            end else begin
                res_tok.arity = ARITY_NONE;
            end
            used = CW'(best_len);
        end else begin
            res_tok.token_kind   = KIND_ERROR;
            res_tok.value_start  = v_pos[0];
            res_tok.value_length = 16'd1;
            used                 = CW'(1);
        end
    end

    always_comb begin
        n_chr       = r_chr;
        n_cpos      = r_cpos;
        n_n         = r_n;
        n_m         = r_m;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_pe        = r_pe;
        n_pv        = r_pv;
        n_pos       = r_pos;
        n_flush     = r_flush;
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_out       = r_out;
        n_out_v     = r_out_v && i_stall;
        can_emit    = !r_out_v || !i_stall;
        hold_mode   = r_flush || (src_q && i_q_item.last);
        sh_amt      = CW'(1);
        do_emit     = 1'b0;
        tok         = run_tok;
        o_q_pop     = 1'b0;

        if (pend || src_q) begin
            if (r_n == '0 && vb) begin
                if (!r_run) begin
                    n_run       = 1'b1;
                    n_run_start = b_pos;
                    n_run_len   = 16'd1;
                end else if (r_run_len != '1) begin
                    n_run_len = r_run_len + 16'd1;
                end
                n_pe    = is_e;
                n_chr   = sh_chr;
                n_cpos  = sh_pos;
                n_m     = m_eff - CW'(1);
                o_q_pop = src_q;
            end else if (r_run) begin
                if (can_emit) begin
                    do_emit = 1'b1;
                    n_run   = 1'b0;
                    n_pv    = 1'b1;
                end
            end else if (r_n == '0 && b == CH_COMMA) begin
                n_pe    = 1'b0;
                n_chr   = sh_chr;
                n_cpos  = sh_pos;
                n_m     = m_eff - CW'(1);
                o_q_pop = src_q;
            end else if (eval_cnt < CW'(DEPTH) && waiting) begin
                n_pe    = is_e;
                n_chr   = v_chr;
                n_cpos  = v_pos;
                n_n     = eval_cnt;
                n_m     = m_eff;
                o_q_pop = src_q;
            end else if (can_emit) begin
                n_pe    = is_e;
                do_emit = 1'b1;
                tok     = res_tok;
                if (best_len != '0) begin
                    n_pv = (best_idx == IDX_RPAREN);
                end
                sh_amt  = used;
                n_chr   = sh_chr;
                n_cpos  = sh_pos;
                n_n     = '0;
                n_m     = m_eff - used;
                o_q_pop = src_q;
            end
            if (o_q_pop) begin
                n_pos   = r_pos + POSITION_BITS'(1);
                n_flush = i_q_item.last;
            end
        end else if (r_flush) begin
            if (r_n != '0) begin
                if (can_emit) begin
                    do_emit = 1'b1;
                    tok     = res_tok;
                    if (best_len != '0) begin
                        n_pv = (best_idx == IDX_RPAREN);
                    end
                    sh_amt = used;
                    n_chr  = sh_chr;
                    n_cpos = sh_pos;
                    n_n    = '0;
                    n_m    = r_m - used;
                end
            end else if (r_run) begin
                if (can_emit) begin
                    do_emit = 1'b1;
                    n_run   = 1'b0;
                    n_pv    = 1'b1;
                end
            end else if (can_emit) begin
                if (r_hold_v) begin
                    n_out            = r_hold;
                    n_out.last_token = 1'b1;
                    n_out_v          = 1'b1;
                end
                n_hold_v = 1'b0;
                n_pe     = 1'b0;
                n_pv     = 1'b0;
                n_pos    = '0;
                n_flush  = 1'b0;
            end
        end else if (bare_q) begin
            o_q_pop = 1'b1;
            n_flush = i_q_item.last;
        end

        if (do_emit) begin
            if (hold_mode) begin
                n_hold   = tok;
                n_hold_v = 1'b1;
                if (r_hold_v) begin
                    n_out   = r_hold;
                    n_out_v = 1'b1;
                end
            end else begin
                n_out   = tok;
                n_out_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_m      <= '0;
            r_run    <= 1'b0;
            r_pe     <= 1'b0;
            r_pv     <= 1'b0;
            r_pos    <= '0;
            r_flush  <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_n      <= n_n;
            r_m      <= n_m;
            r_run    <= n_run;
            r_pe     <= n_pe;
            r_pv     <= n_pv;
            r_pos    <= n_pos;
            r_flush  <= n_flush;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chr       <= n_chr;
        r_cpos      <= n_cpos;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_hold      <= n_hold;
        r_out       <= n_out;
    end

    assign o_valid = r_out_v;
    assign o_token = r_out;

endmodule

### rtl/core/expression_lexer.sv
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming lexer for arithmetic expression text, one byte per transaction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_item  (char byte, last flag)
//  output    out        o_valid / i_stall   o_token (kind, index, arity, value)
//
// The engine takes one byte per cycle unless a value run closes, left-over bytes wait
// or the output stalls. Closing an open value run is a step of its own, and each byte
// left over after a name match is examined again, one byte per cycle unless the
// output stalls. After the last byte the pending tokens are flushed in order and the
// last one is marked. Reset is synchronous; an output stall holds the engine while the
// input queue fills.
module expression_lexer #(
    parameter int POSITION_BITS   = exl_pkg::POSITION_BITS_DEF,
    parameter int LOOKAHEAD_DEPTH = exl_pkg::LOOKAHEAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  exl_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output exl_pkg::t_out o_token
);
    import exl_pkg::*;

    logic  q_push, q_full, q_pop, q_valid;
    t_item q_in, q_head;

    exl_front u_front (
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    exl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    exl_back #(
        .POSITION_BITS   (POSITION_BITS),
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_token   (o_token)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_value_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token.token_kind == KIND_VALUE) |-> o_token.value_length != 16'd0)
        else $error("value token with zero length");

endmodule

### bench/expression_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_lexer_tb
// Self-checking bench for the streaming expression lexer. Byte streams are
// sent through the input channel, the tokens they should produce are worked
// out by a bench-side lexer, and every output transaction is compared with
// the oldest pending token, under several idling and back-pressure regimes.
// ----------------------------------------------------------------------------
module expression_lexer_tb;
    import exl_pkg::*;

    localparam int LA_DEPTH = 7;
    localparam int RUN_MAX  = 65535;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_token;

    expression_lexer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (o_token)
    );

    // Bench-side lexer state.
    logic [7:0]  la_byte [LA_DEPTH];
    logic [15:0] la_pos  [LA_DEPTH];
    int          la_cnt;
    bit          run_open;
    logic [15:0] run_first;
    int          run_len;
    bit          after_e;
    bit          after_operand;
    logic [15:0] text_pos;

    t_out token_q [$];
    t_out step_toks [$];

    int idle_pct;
    int stall_pct;
    int hold_cycles;
    int fail_count;
    int bytes_sent;
    int tokens_seen;
    int expr_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] name_byte(int idx, int k);
        logic [55:0] w;
        w = NAME_TEXT[idx] >> (8 * (int'(NAME_LEN[idx]) - 1 - k));
        return w[7:0];
    endfunction

    function automatic t_kind kind_for(int idx);
        if (idx <= 1) return KIND_PAREN;
        if ((idx >= 15 && idx <= 28) || (idx >= 37 && idx <= 40)) return KIND_FUNC;
        return KIND_OPER;
    endfunction

    function automatic void push_token(t_kind k, int idx, logic [1:0] ar,
                                       logic [15:0] st, logic [15:0] len);
        t_out t;
        t.token_kind   = k;
        t.name_index   = 6'(idx);
        t.arity        = ar;
        t.value_start  = st;
        t.value_length = len;
        t.last_token   = 1'b0;
        if (step_toks.size() < 8) step_toks = {step_toks, t};
    endfunction

    function automatic void end_run();
        if (!run_open) return;
        push_token(KIND_VALUE, 0, ARITY_NONE, run_first, 16'(run_len));
        after_operand = 1'b1;
        run_open = 1'b0;
    endfunction

    function automatic bit buf_has(int idx, int n);
        for (int k = 0; k < n; k++)
            if (name_byte(idx, k) != la_byte[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit prefix_pending();
        for (int i = 0; i < NAME_COUNT; i++)
            if (int'(NAME_LEN[i]) > la_cnt && buf_has(i, la_cnt)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void match_names(bit flush);
        int best_len;
        int best_idx;
        int used;
        int rest;
        logic [7:0]  rb [LA_DEPTH];
        logic [15:0] rp [LA_DEPTH];
        logic [1:0]  ar;
        best_len = 0;
        best_idx = 0;
        if (la_cnt == 0) return;
        if (!flush && la_cnt < LA_DEPTH && prefix_pending()) return;
        for (int i = 0; i < NAME_COUNT; i++)
            if (int'(NAME_LEN[i]) <= la_cnt && int'(NAME_LEN[i]) > best_len
                && buf_has(i, int'(NAME_LEN[i]))) begin
                best_len = int'(NAME_LEN[i]);
                best_idx = i;
            end
        if (best_len > 0) begin
            ar = ARITY_NONE;
            if (best_idx == int'(IDX_PLUS) || best_idx == int'(IDX_MINUS))
                ar = after_operand ? ARITY_BINARY : ARITY_UNARY;
            push_token(kind_for(best_idx), best_idx, ar, 16'd0, 16'd0);
            after_operand = (best_idx == int'(IDX_RPAREN));
            used = best_len;
        end else begin
            push_token(KIND_ERROR, 0, ARITY_NONE, la_pos[0], 16'd1);
            used = 1;
        end
        rest = la_cnt - used;
        for (int j = 0; j < rest; j++) begin
            rb[j] = la_byte[used + j];
            rp[j] = la_pos[used + j];
        end
        la_cnt = 0;
        for (int j = 0; j < rest; j++) absorb(rb[j], rp[j]);
    endfunction

    function automatic void absorb(logic [7:0] b, logic [15:0] p);
        bit numeric;
        numeric = (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_E
                  || ((b == CH_PLUS || b == CH_MINUS) && after_e);
        if (la_cnt == 0 && numeric) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = p;
                run_len   = 1;
            end else if (run_len < RUN_MAX) begin
                run_len++;
            end
            after_e = (b == CH_E);
            return;
        end
        end_run();
        after_e = (b == CH_E);
        if (la_cnt == 0 && b == CH_COMMA) return;
        if (la_cnt >= LA_DEPTH) match_names(1'b1);
        if (la_cnt < LA_DEPTH) begin
            la_byte[la_cnt] = b;
            la_pos[la_cnt]  = p;
            la_cnt++;
        end
        match_names(1'b0);
    endfunction

    function automatic void clear_lexer();
        la_cnt        = 0;
        run_open      = 1'b0;
        run_first     = '0;
        run_len       = 0;
        after_e       = 1'b0;
        after_operand = 1'b0;
        text_pos      = '0;
    endfunction

    function automatic void predict_byte(logic [7:0] raw, bit last);
        logic [7:0]  b;
        logic [15:0] p;
        b = raw;
        step_toks.delete();
        if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
            p = text_pos;
            if (b >= CH_UA && b <= CH_UZ) b = b + CASE_GAP;
            text_pos = text_pos + 16'd1;
            absorb(b, p);
        end
        if (last) begin
            while (la_cnt > 0) match_names(1'b1);
            end_run();
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_token = 1'b1;
            clear_lexer();
        end
        token_q = {token_q, step_toks};
    endfunction

    task automatic send_byte(logic [7:0] b, bit last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{char_byte: b, last_char: last};
        do @(posedge i_clk); while (o_stall);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
        expr_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (token_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            tokens_seen++;
            if (token_q.size() == 0) begin
                $error("unexpected token kind=%0d index=%0d", o_token.token_kind,
                       o_token.name_index);
                fail_count++;
            end else begin
                e = token_q.pop_front();
                if (o_token.token_kind !== e.token_kind) begin
                    $error("token_kind expected %0d actual %0d", e.token_kind,
                           o_token.token_kind);
                    fail_count++;
                end
                if (o_token.name_index !== e.name_index) begin
                    $error("name_index expected %0d actual %0d", e.name_index,
                           o_token.name_index);
                    fail_count++;
                end
                if (o_token.arity !== e.arity) begin
                    $error("arity expected %0d actual %0d", e.arity, o_token.arity);
                    fail_count++;
                end
                if (o_token.value_start !== e.value_start) begin
                    $error("value_start expected %0d actual %0d", e.value_start,
                           o_token.value_start);
                    fail_count++;
                end
                if (o_token.value_length !== e.value_length) begin
                    $error("value_length expected %0d actual %0d", e.value_length,
                           o_token.value_length);
                    fail_count++;
                end
                if (o_token.last_token !== e.last_token) begin
                    $error("last_token expected %0d actual %0d", e.last_token,
                           o_token.last_token);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_text("(3+-2)*Abs(1.5E+3)");
        send_text("a/=b!=c~=d<=e>=f==g");
        send_text("ceiling(x)+ceil,1,2 ^ 3%4");
        send_text("&&&||<<>>!~|&<>");
        send_text({"acos asin floor ", 8'hC2, 8'hB0, 8'hC2, "#", 8'hFF, 8'h00, 8'h80});
        send_text("1e-5-2e+x");
        send_text("cei");
        send_text("  \t\n");
        send_text({8'h0B, 8'h0C, 8'h0D});
        send_text("1");
    endtask

    function automatic string random_piece();
        string s;
        int idx;
        case ($urandom_range(9))
            0, 1, 2: begin
                s = "";
                repeat ($urandom_range(1, 4)) s = {s, 8'(CH_ZERO + $urandom_range(9))};
                if ($urandom_range(2) == 0) s = {s, ".5"};
                if ($urandom_range(3) == 0) s = {s, ($urandom_range(1) ? "E-" : "e+"), "7"};
            end
            3, 4, 5, 6: begin
                idx = $urandom_range(NAME_COUNT - 1);
                s = "";
                for (int k = 0; k < int'(NAME_LEN[idx]); k++) begin
                    s = {s, name_byte(idx, k)};
                    if (name_byte(idx, k) >= 8'h61 && name_byte(idx, k) <= 8'h7A
                        && $urandom_range(3) == 0)
                        s[s.len() - 1] = name_byte(idx, k) - CASE_GAP;
                end
            end
            7: s = ($urandom_range(1) ? " " : ",");
            8: s = {8'($urandom_range(255))};
            default: s = ($urandom_range(1) ? "\t" : "(");
        endcase
        return s;
    endfunction

    task automatic test_random(int n_bytes, int idle, int stall);
        string s;
        int sent;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_bytes) begin
            s = "";
            repeat ($urandom_range(1, 8)) s = {s, random_piece()};
            send_text(s);
            sent += s.len();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        send_text("sin(1)+cos(2)*tan(3.0e-1)");
        wait_drained();
        send_text("(1+2)");
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_stall     = 1'b0;
        hold_cycles = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        fail_count  = 0;
        bytes_sent  = 0;
        tokens_seen = 0;
        expr_count  = 0;
        clear_lexer();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_random(12, 0, 0);
        test_random(12, 85, 0);
        test_random(12, 0, 85);
        test_random(12, 32, 32);
        test_backpressure();

        $display("Lexed %0d bytes in %0d expressions, %0d tokens checked.",
                 bytes_sent, expr_count, tokens_seen);
        $display("Covered names, errors, value runs, idling and output back-pressure.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/exl_pkg.sv
rtl/core/exl_front.sv
rtl/core/exl_queue.sv
rtl/core/exl_back.sv
rtl/core/expression_lexer.sv
bench/expression_lexer_tb.sv
